// ===== design/mmroe_pkg.sv =====
// Shared types, constants and helpers for the mark-matrix row offset encoder.
package mmroe_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int ROW_WIDTH_RESET   = 1024;

   localparam int SYMBOL_W     = 2;
   localparam int ROW_WIDTH_W  = 11;
   localparam int CODE_BITS_W  = 13;
   localparam int CODE_LEN_W   = 4;

   // Working width for the ceiling log2 and the unmasked code word.
   // It covers an effective width up to 131071 (17 bits).
   localparam int LOG_IN_W     = 17;
   localparam int LOG_OUT_W    = 5;
   localparam int CODE_WIDE_W  = 3 + LOG_IN_W;

   typedef enum logic [SYMBOL_W-1:0] {
      SYM_INTERIOR = 2'd0,
      SYM_START    = 2'd1,
      SYM_END      = 2'd2,
      SYM_SINGLE   = 2'd3
   } symbol_type;

   localparam logic [2:0] PREFIX_START  = 3'b011;
   localparam logic [2:0] PREFIX_END    = 3'b101;
   localparam logic [2:0] PREFIX_SINGLE = 3'b100;
   localparam logic [1:0] PLEN_SHORT    = 2'd2;
   localparam logic [1:0] PLEN_LONG     = 2'd3;

   // Smallest b with 2^b >= n (n of 0 or 1 gives 0).
   function automatic logic [LOG_OUT_W-1:0] ceil_log2(input logic [LOG_IN_W-1:0] n);
      logic [LOG_IN_W-1:0]  n_m1;
      logic [LOG_OUT_W-1:0] b;
      n_m1 = (n == '0) ? '0 : n - LOG_IN_W'(1);
      b = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
         if (n_m1[i]) begin
            b = LOG_OUT_W'(i + 1);
         end
      end
      return b;
   endfunction

endpackage

// ===== design/mark_matrix_row_offset_encoder_core.sv =====
// Mark-matrix row offset encoder: one symbol in, at most one variable-length code word out.
//
// Accepts one mark symbol per clock cycle while req_stall is low. An accepted symbol is held in
// an input register, its code word is formed there and loaded into the result register,
// which raises rsp_valid; that load waits while a held result is stalled by rsp_stall.
// Zero symbols outside the last column of a row produce no result.
// The row state (column, last nonzero column) is updated at the input transfer, which
// sets the one-symbol-per-cycle rate.
// A write on the csr channel sets the row width (clamped to 1..MAX_WIDTH) and restarts
// the row; csr_ready is always high and writes are meant to occur only while idle.
module mark_matrix_row_offset_encoder_core
   import mmroe_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SYMBOL_W-1:0]    req_symbol,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CODE_BITS_W-1:0] rsp_code_bits,
   output logic [CODE_LEN_W-1:0]  rsp_code_length,
   output logic                   rsp_row_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ROW_WIDTH_W-1:0] csr_row_width
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int W_RESET = (ROW_WIDTH_RESET < MAX_WIDTH) ? ROW_WIDTH_RESET : MAX_WIDTH;

   logic [WW-1:0]    w_ff, w_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] lnz_ff, lnz_in;
   logic             seen_ff, seen_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [SYMBOL_W-1:0] s1_sym_ff;
   logic [COL_W-1:0]    s1_col_ff, s1_lnz_ff;
   logic                s1_seen_ff, s1_last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS_W-1:0] rsp_code_bits_ff;
   logic [CODE_LEN_W-1:0]  rsp_code_length_ff;
   logic                   rsp_row_end_ff;

   logic req_xfer, csr_xfer, cur_last;
   logic s1_has, s1_move, out_free, out_load;

   logic [WW-1:0]          remaining, remaining_c;
   logic [COL_W-1:0]       offset;
   logic [LOG_OUT_W-1:0]   b_raw, b;
   logic [2:0]             prefix;
   logic [1:0]             plen;
   logic [CODE_WIDE_W-1:0] code_wide;
   logic [CODE_BITS_W-1:0] code_bits;
   logic [CODE_LEN_W-1:0]  code_len;
   logic [LOG_OUT_W:0]     len_sum;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_xfer  = req_valid && !req_stall;
   assign cur_last  = (WW'(col_ff) >= (w_ff - WW'(1)));

   // Front state: updated at each input transfer and at each csr write
   always_comb begin
      w_in    = w_ff;
      col_in  = col_ff;
      lnz_in  = lnz_ff;
      seen_in = seen_ff;
      if (csr_xfer) begin
         if (csr_row_width == '0) begin
            w_in = WW'(1);
         end else if (32'(csr_row_width) > 32'(MAX_WIDTH)) begin
            w_in = WW'(MAX_WIDTH);
         end else begin
            w_in = WW'(csr_row_width);
         end
         col_in  = '0;
         lnz_in  = '0;
         seen_in = 1'b0;
      end else if (req_xfer) begin
         if (cur_last) begin
            col_in  = '0;
            lnz_in  = '0;
            seen_in = 1'b0;
         end else begin
            col_in = col_ff + COL_W'(1);
            if (req_symbol != SYM_INTERIOR) begin
               lnz_in  = col_ff;
               seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= WW'(W_RESET);
         col_ff  <= '0;
         lnz_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         w_ff    <= w_in;
         col_ff  <= col_in;
         lnz_ff  <= lnz_in;
         seen_ff <= seen_in;
      end
   end

   // Input register stage
   assign s1_has   = s1_valid_ff && ((s1_sym_ff != SYM_INTERIOR) || s1_last_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move  = out_free || !s1_has;
   assign out_load = s1_has && out_free;
   assign req_stall = s1_valid_ff && !s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sym_ff  <= req_symbol;
         s1_col_ff  <= col_ff;
         s1_lnz_ff  <= lnz_ff;
         s1_seen_ff <= seen_ff;
         s1_last_ff <= cur_last;
      end
   end

   // Code word formation
   always_comb begin
      if (s1_seen_ff) begin
         remaining = w_ff - WW'(s1_lnz_ff) - WW'(1);
         offset    = s1_col_ff - s1_lnz_ff - COL_W'(1);
      end else begin
         remaining = w_ff;
         offset    = s1_col_ff;
      end
      remaining_c = (remaining == '0) ? WW'(1) : remaining;
      b_raw = ceil_log2(LOG_IN_W'(remaining_c));
      b     = (b_raw == '0) ? LOG_OUT_W'(1) : b_raw;

      case (s1_sym_ff)
         SYM_START: begin
            prefix = PREFIX_START;
            plen   = PLEN_SHORT;
         end
         SYM_END: begin
            prefix = PREFIX_END;
            plen   = PLEN_LONG;
         end
         default: begin
            prefix = PREFIX_SINGLE;
            plen   = PLEN_LONG;
         end
      endcase

      code_wide = (CODE_WIDE_W'(prefix) << b)
                | (CODE_WIDE_W'(offset) & ((CODE_WIDE_W'(1) << b) - CODE_WIDE_W'(1)));
      len_sum   = (LOG_OUT_W+1)'(plen) + (LOG_OUT_W+1)'(b);

      if (s1_sym_ff == SYM_INTERIOR) begin
         code_bits = '0;
         code_len  = CODE_LEN_W'(1);
      end else begin
         code_bits = code_wide[CODE_BITS_W-1:0];
         code_len  = len_sum[CODE_LEN_W-1:0];
      end
   end

   // Result register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_code_bits_ff   <= code_bits;
         rsp_code_length_ff <= code_len;
         rsp_row_end_ff     <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_bits   = rsp_code_bits_ff;
   assign rsp_code_length = rsp_code_length_ff;
   assign rsp_row_end     = rsp_row_end_ff;

endmodule
